// ----- src/skm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skm_pkg
// Shared types, codes and scale tables for the last-note-priority key assigner.
// ----------------------------------------------------------------------------
package skm_pkg;

  localparam int HELD_DEPTH = 8;
  localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HELD_DEPTH + 1);

  // request codes on the input channel
  localparam logic [1:0] REQ_PRESS   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_PANIC   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SCALE   = 3'd0;
  localparam logic [2:0] REG_OCTAVE  = 3'd1;
  localparam logic [2:0] REG_LIVE    = 3'd2;
  localparam logic [2:0] REG_ROOT    = 3'd3;
  localparam logic [2:0] REG_LOWEST  = 3'd4;
  localparam logic [2:0] REG_HIGHEST = 3'd5;

  // scale select codes
  localparam logic [2:0] SCALE_CHROM  = 3'd0;
  localparam logic [2:0] SCALE_MAJOR  = 3'd1;
  localparam logic [2:0] SCALE_MINOR  = 3'd2;
  localparam logic [2:0] SCALE_PENTA  = 3'd3;
  localparam logic [2:0] SCALE_DORIAN = 3'd4;

  localparam int MAX_DEG = 10;

  // interval for each degree, octave wrap already folded in
  localparam logic [4:0] MAJOR_IV  [MAX_DEG+1] =
    '{5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9, 5'd11, 5'd12, 5'd14, 5'd16, 5'd17};
  localparam logic [4:0] MINOR_IV  [MAX_DEG+1] =
    '{5'd0, 5'd2, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12, 5'd14, 5'd15, 5'd17};
  localparam logic [4:0] PENTA_IV  [MAX_DEG+1] =
    '{5'd0, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd15, 5'd17, 5'd19, 5'd22, 5'd24};
  localparam logic [4:0] DORIAN_IV [MAX_DEG+1] =
    '{5'd0, 5'd2, 5'd3, 5'd5, 5'd7, 5'd9, 5'd10, 5'd12, 5'd14, 5'd15, 5'd17};

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ON      = 2'd1,
    EV_OFF     = 2'd2,
    EV_ALL_OFF = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PANIC   = 2'd2,
    OP_REFUSE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
    logic [6:0] note;
    logic [7:0] vel;
  } cmd_t;

  typedef struct packed {
    logic [7:0] key;
    logic [6:0] note;
    logic [7:0] vel;
  } held_t;

  typedef struct packed {
    logic       accepted;
    ev_kind_t   kind;
    logic [6:0] note;
    logic [7:0] vel;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] deg;
  } deg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_TOP,
    S_EMIT
  } back_state_t;

  function automatic logic [7:0] fold_key(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (code >= "A" && code <= "Z") begin
      c = code + 8'd32;
    end
    return c;
  endfunction

  function automatic deg_t key_degree(input logic [7:0] key);
    deg_t d;
    d.ok  = 1'b1;
    d.deg = 4'd0;
    case (key)
      "a":     d.deg = 4'd0;
      "s":     d.deg = 4'd1;
      "d":     d.deg = 4'd2;
      "f":     d.deg = 4'd3;
      "g":     d.deg = 4'd4;
      "h":     d.deg = 4'd5;
      "j":     d.deg = 4'd6;
      "k":     d.deg = 4'd7;
      "l":     d.deg = 4'd8;
      "q":     d.deg = 4'd1;
      "w":     d.deg = 4'd2;
      "e":     d.deg = 4'd3;
      "r":     d.deg = 4'd4;
      "t":     d.deg = 4'd5;
      "y":     d.deg = 4'd6;
      "u":     d.deg = 4'd7;
      "i":     d.deg = 4'd8;
      "o":     d.deg = 4'd9;
      "p":     d.deg = 4'd10;
      default: d.ok  = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] interval_of(input logic [2:0] scale,
                                             input logic [3:0] deg);
    logic [4:0] iv;
    iv = 5'd0;
    if (deg <= 4'(MAX_DEG)) begin
      case (scale)
        SCALE_CHROM:  iv = {1'b0, deg};
        SCALE_MAJOR:  iv = MAJOR_IV[deg];
        SCALE_MINOR:  iv = MINOR_IV[deg];
        SCALE_PENTA:  iv = PENTA_IV[deg];
        SCALE_DORIAN: iv = DORIAN_IV[deg];
        default:      iv = 5'd0;
      endcase
    end
    return iv;
  endfunction

endpackage
`default_nettype wire

// ----- src/scale_key_last_note_priority.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scale_key_last_note_priority
// Monophonic key assigner: maps keyboard rows to scale notes and keeps a
// last-note-priority stack of held keys, reporting note events.
//
//   channel  direction  handshake           payload
//   in_      into block in_push / in_full   req_type, key_code, press_velocity
//   out_     out        out_empty / out_pop accepted, event_kind, note_number,
//                                           event_velocity
//   cfg_     into block cfg_valid/cfg_ready index, data (always ready)
//
// From input transfer to result, the stack engine walks the held stack one
// entry per cycle to find the key, then, for a release, compacts it one entry
// per cycle.
// A two-entry command queue lets the input side keep taking items meanwhile.
// Reset is synchronous, active low; the stack is empty after reset.
// A held result stalls the engine until out_pop takes it.
// ----------------------------------------------------------------------------
module scale_key_last_note_priority import skm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_key_code,
  input  wire logic [7:0] in_press_velocity,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_accepted,
  output logic [1:0]      out_event_kind,
  output logic [6:0]      out_note_number,
  output logic [7:0]      out_event_velocity,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  cmd_t front_cmd;
  cmd_t q_head;
  logic q_valid, q_pop;
  logic out_valid;
  res_t out_res;

  skm_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_req_type       (in_req_type),
    .in_key_code       (in_key_code),
    .in_press_velocity (in_press_velocity),
    .cmd               (front_cmd)
  );

  skm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_cmd (front_cmd),
    .full     (in_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  skm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_pop   (out_pop)
  );

  assign out_empty          = !out_valid;
  assign out_accepted       = out_res.accepted;
  assign out_event_kind     = out_res.kind;
  assign out_note_number    = out_res.note;
  assign out_event_velocity = out_res.vel;

endmodule
`default_nettype wire

// ----- src/skm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skm_front
// Configuration registers, key folding, note mapping and request classing.
// ----------------------------------------------------------------------------
module skm_front import skm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_key_code,
  input  wire logic [7:0] in_press_velocity,
  output cmd_t            cmd
);

  logic [2:0] scale_r,  scale_nxt;
  logic [2:0] octave_r, octave_nxt;
  logic       live_r,   live_nxt;
  logic [6:0] root_r,   root_nxt;
  logic [6:0] lowest_r, lowest_nxt;
  logic [6:0] highest_r, highest_nxt;

  logic [7:0]        key_f;
  deg_t              dg;
  logic [4:0]        iv;
  logic signed [8:0] oct8, oct4, note_s;
  logic              in_range;

  assign cfg_ready = 1'b1;

  always_comb begin
    scale_nxt   = scale_r;
    octave_nxt  = octave_r;
    live_nxt    = live_r;
    root_nxt    = root_r;
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE:   scale_nxt   = cfg_data[2:0];
        REG_OCTAVE:  octave_nxt  = cfg_data[2:0];
        REG_LIVE:    live_nxt    = cfg_data[0];
        REG_ROOT:    root_nxt    = cfg_data;
        REG_LOWEST:  lowest_nxt  = cfg_data;
        REG_HIGHEST: highest_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_CHROM;
      octave_r  <= 3'd0;
      live_r    <= 1'b1;
      root_r    <= 7'd48;
      lowest_r  <= 7'd24;
      highest_r <= 7'd71;
    end else begin
      scale_r   <= scale_nxt;
      octave_r  <= octave_nxt;
      live_r    <= live_nxt;
      root_r    <= root_nxt;
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
    end
  end

  // note = root + 12 * octave + interval, as a signed 9-bit sum
  always_comb begin
    key_f    = fold_key(in_key_code);
    dg       = key_degree(key_f);
    iv       = interval_of(scale_r, dg.deg);
    oct8     = $signed({{3{octave_r[2]}}, octave_r, 3'b000});
    oct4     = $signed({{4{octave_r[2]}}, octave_r, 2'b00});
    note_s   = $signed({2'b00, root_r}) + oct8 + oct4 + $signed({4'b0000, iv});
    in_range = (note_s >= $signed({2'b00, lowest_r})) &&
               (note_s <= $signed({2'b00, highest_r}));
  end

  always_comb begin
    cmd.key  = key_f;
    cmd.note = note_s[6:0];
    cmd.vel  = in_press_velocity;
    case (in_req_type)
      REQ_PRESS:   cmd.op = (live_r && dg.ok && in_range) ? OP_PRESS : OP_REFUSE;
      REQ_RELEASE: cmd.op = OP_RELEASE;
      REQ_PANIC:   cmd.op = OP_PANIC;
      default:     cmd.op = OP_REFUSE;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/skm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skm_queue
// Two-entry command queue between the classifying front and the stack engine.
// ----------------------------------------------------------------------------
module skm_queue import skm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r,    cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- src/skm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skm_back
// Held-key stack engine: searches, pushes and compacts the last-note stack
// one entry per cycle, and holds the result for the output side.
// ----------------------------------------------------------------------------
module skm_back import skm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  output res_t      out_res,
  input  wire logic out_pop
);

  back_state_t state_r, state_nxt;

  held_t      held_r [HELD_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r,   idx_nxt;
  cmd_t       cmd_r,   cmd_nxt;
  res_t       res_r,   res_nxt;
  logic       top_r,   top_nxt;
  logic [6:0] rel_r,   rel_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r,   out_res_nxt;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  held_t            rd_data, wr_data;
  logic             wr_en;
  logic [CNT_W-1:0] count_dec;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign count_dec = count_r - CNT_W'(1);

  // single read site: new top in S_TOP, search/shift walk at idx otherwise
  assign rd_addr = (state_r == S_TOP) ? count_dec[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign rd_data = held_r[rd_addr];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.op == OP_PRESS || q_head.op == OP_RELEASE) ?
                      S_SEARCH : S_EMIT;
        end
      end
      S_SEARCH: begin
        if (idx_r == count_r) begin
          state_nxt = S_EMIT;
        end else if (rd_data.key == cmd_r.key) begin
          state_nxt = (cmd_r.op == OP_RELEASE) ? S_SHIFT : S_EMIT;
        end
      end
      S_SHIFT: begin
        if (idx_r >= count_r) begin
          state_nxt = (top_r && count_dec != '0) ? S_TOP : S_EMIT;
        end
      end
      S_TOP:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    top_nxt       = top_r;
    rel_nxt       = rel_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = rd_data;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_head;
          idx_nxt = '0;
          res_nxt = '{accepted: 1'b0, kind: EV_NONE, note: 7'd0, vel: 8'd0};
          if (q_head.op == OP_PANIC) begin
            count_nxt = '0;
            res_nxt   = '{accepted: 1'b1, kind: EV_ALL_OFF, note: 7'd0, vel: 8'd0};
          end
        end
      end
      S_SEARCH: begin
        if (idx_r == count_r) begin
          // key not held
          if (cmd_r.op == OP_PRESS) begin
            if (count_r == CNT_W'(HELD_DEPTH)) begin
              count_nxt = '0;
              res_nxt   = '{accepted: 1'b0, kind: EV_ALL_OFF, note: 7'd0, vel: 8'd0};
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              wr_data   = '{key: cmd_r.key, note: cmd_r.note, vel: cmd_r.vel};
              count_nxt = count_r + CNT_W'(1);
              res_nxt   = '{accepted: 1'b1, kind: EV_ON, note: cmd_r.note,
                            vel: cmd_r.vel};
            end
          end
        end else if (rd_data.key == cmd_r.key) begin
          res_nxt.accepted = 1'b1;
          top_nxt = (idx_r + CNT_W'(1) == count_r);
          rel_nxt = rd_data.note;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        if (idx_r < count_r) begin
          // move entry down over the released slot
          wr_en   = 1'b1;
          wr_addr = idx_r[IDX_W-1:0] - IDX_W'(1);
          wr_data = rd_data;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          count_nxt = count_dec;
          if (top_r && count_dec == '0) begin
            res_nxt = '{accepted: 1'b1, kind: EV_OFF, note: rel_r, vel: 8'd0};
          end
        end
      end
      S_TOP: begin
        res_nxt = '{accepted: 1'b1, kind: EV_ON, note: rd_data.note, vel: rd_data.vel};
      end
      S_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    top_r     <= top_nxt;
    rel_r     <= rel_nxt;
    out_res_r <= out_res_nxt;
    if (wr_en) begin
      held_r[wr_addr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HELD_DEPTH))
    else $error("held count beyond stack depth");

  a_panic_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid && q_head.op == OP_PANIC) |=> count_r == '0)
    else $error("panic did not clear the stack");

  a_search_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> idx_r <= count_r)
    else $error("search ran past the held entries");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into output register");

endmodule
`default_nettype wire
